// ===== rtl/core/gai_pkg.sv =====
// Shared types, constants and helpers for the gyro average angle integrator.
`timescale 1ns / 1ps
`default_nettype none

package gai_pkg;

    localparam int WINDOW     = 16;
    localparam int N_AXES     = 3;
    localparam int RAW_W      = 16;
    localparam int DT_W       = 16;
    localparam int DB_W       = 15;
    localparam int CORR_W     = 17;
    localparam int RATE_W     = 17;
    localparam int ANGLE_W    = 48;
    localparam int SHIFT_K    = $clog2(WINDOW + 1) - 1;
    localparam int SUM_W      = CORR_W + $clog2(WINDOW);
    localparam int PROD_W     = RATE_W + DT_W + 1;
    localparam int RING_W     = N_AXES * CORR_W;
    localparam int RING_AW    = $clog2(WINDOW);
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int QDEPTH     = 2;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RATE_MAX   = 2 ** (RATE_W - 1) - 1;
    localparam int RATE_MIN   = -(2 ** (RATE_W - 1));

    localparam logic [DB_W-1:0] DEADBAND_RST = DB_W'(4);

    localparam logic signed [SUM_W-1:0] SUM_RATE_HI = SUM_W'(RATE_MAX);
    localparam logic signed [SUM_W-1:0] SUM_RATE_LO = SUM_W'(RATE_MIN);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_OFFSET_X = 3'd1,
        REG_OFFSET_Y = 3'd2,
        REG_OFFSET_Z = 3'd3,
        REG_DEADBAND = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                                enable;
        logic [N_AXES-1:0][RAW_W-1:0]        offset;
        logic [DB_W-1:0]                     deadband;
    } t_cfg;

    typedef struct packed {
        logic                                en;
        logic [DT_W-1:0]                     dt;
        logic [N_AXES-1:0][CORR_W-1:0]       cur;
    } t_item;

    // offset removal followed by deadband zeroing
    function automatic logic [CORR_W-1:0] correct(
        input logic [RAW_W-1:0] raw,
        input logic [RAW_W-1:0] off,
        input logic [DB_W-1:0]  db
    );
        logic signed [CORR_W-1:0] c;
        logic        [CORR_W-1:0] mag;
        c   = $signed({raw[RAW_W-1], raw}) - $signed({off[RAW_W-1], off});
        mag = c[CORR_W-1] ? CORR_W'(-c) : CORR_W'(c);
        if (mag < CORR_W'(db)) begin
            correct = '0;
        end else begin
            correct = c;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gai_in_if.sv =====
// Input channel: one raw three-axis gyro sample with its time step.
`timescale 1ns / 1ps
`default_nettype none

interface gai_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] gyro_x;
    logic [15:0] gyro_y;
    logic [15:0] gyro_z;
    logic [15:0] elapsed_us;

    modport source (output valid, output gyro_x, output gyro_y, output gyro_z,
                    output elapsed_us, input ready);
    modport sink   (input valid, input gyro_x, input gyro_y, input gyro_z,
                    input elapsed_us, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gai_out_if.sv =====
// Output channel: averaged rates and integrated angles.
`timescale 1ns / 1ps
`default_nettype none

interface gai_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] rate_x;
    logic [16:0] rate_y;
    logic [16:0] rate_z;
    logic [47:0] angle_x;
    logic [47:0] angle_y;
    logic [47:0] angle_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z,
                    output angle_x, output angle_y, output angle_z, input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z,
                    input angle_x, input angle_y, input angle_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gyro_average_angle_integrator.sv =====
// Top level of the gyro moving-average angle integrator.
//
//   channel   dir  handshake        payload
//   i_gyro    in   valid / ready    gyro_x, gyro_y, gyro_z, elapsed_us
//   o_result  out  valid / ready    rate_x/y/z, angle_x/y/z
//   cfg       in   i_cfg_we         i_cfg_idx, i_cfg_wdata
//
// One item per cycle sustained while the output is not stalled; a result
// follows its accepted item through the queue write at accept, then ring/sum
// update, average and multiply, and angle accumulate.
// The ring RAM takes one write and one look-ahead read per cycle.
// Synchronous active-low reset clears state; the ring needs no clearing.
// An output stall halts the back end; the two-entry queue then fills and
// drops i_gyro.ready.
`timescale 1ns / 1ps
`default_nettype none

module gyro_average_angle_integrator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gai_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gai_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    gai_in_if.sink                              i_gyro,
    gai_out_if.source                           o_result
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    gai_pkg::t_item push_item;
    gai_pkg::t_item q_item;

    gai_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_gyro      (i_gyro),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    gai_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    gai_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/gai_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gai_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/gai_front.sv =====
// Front end: configuration registers, sample correction and queue push.
`timescale 1ns / 1ps
`default_nettype none

module gai_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gai_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gai_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    gai_in_if.sink                              i_gyro,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output gai_pkg::t_item                      o_item
);

    gai_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= 1'b0;
            r_cfg.offset   <= '0;
            r_cfg.deadband <= gai_pkg::DEADBAND_RST;
        end else if (i_cfg_we) begin
            unique case (gai_pkg::t_reg_idx'(i_cfg_idx))
                gai_pkg::REG_ENABLE:   r_cfg.enable    <= i_cfg_wdata[0];
                gai_pkg::REG_OFFSET_X: r_cfg.offset[0] <= i_cfg_wdata[gai_pkg::RAW_W-1:0];
                gai_pkg::REG_OFFSET_Y: r_cfg.offset[1] <= i_cfg_wdata[gai_pkg::RAW_W-1:0];
                gai_pkg::REG_OFFSET_Z: r_cfg.offset[2] <= i_cfg_wdata[gai_pkg::RAW_W-1:0];
                gai_pkg::REG_DEADBAND: r_cfg.deadband  <= i_cfg_wdata[gai_pkg::DB_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_gyro.ready = !i_q_full;
    assign o_push       = i_gyro.valid && !i_q_full;

    always_comb begin
        o_item.en     = r_cfg.enable;
        o_item.dt     = i_gyro.elapsed_us;
        o_item.cur[0] = gai_pkg::correct(i_gyro.gyro_x, r_cfg.offset[0], r_cfg.deadband);
        o_item.cur[1] = gai_pkg::correct(i_gyro.gyro_y, r_cfg.offset[1], r_cfg.deadband);
        o_item.cur[2] = gai_pkg::correct(i_gyro.gyro_z, r_cfg.offset[2], r_cfg.deadband);
    end

endmodule

`default_nettype wire

// ===== rtl/core/gai_queue.sv =====
// Short item queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module gai_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  gai_pkg::t_item       i_item,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output gai_pkg::t_item       o_item
);

    gai_pkg::t_item                r_mem [gai_pkg::QDEPTH];
    logic [gai_pkg::QAW-1:0]       r_wp;
    logic [gai_pkg::QAW-1:0]       r_rp;
    logic [gai_pkg::QAW:0]         r_cnt;
    logic                          do_pop;

    assign o_full  = r_cnt == (gai_pkg::QAW + 1)'(gai_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == gai_pkg::QAW'(gai_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == gai_pkg::QAW'(gai_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gai_back.sv =====
// Back end: sample ring, running sums, averaging and angle integration.
`timescale 1ns / 1ps
`default_nettype none

module gai_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_valid,
    input  gai_pkg::t_item i_q_item,
    output logic           o_q_pop,
    gai_out_if.source      o_result
);

    localparam int NA = gai_pkg::N_AXES;

    logic                                 adv;
    logic                                 take;
    logic                                 ring_full;
    logic [gai_pkg::RING_AW-1:0]          r_pos;
    logic [gai_pkg::RING_AW-1:0]          n_pos;
    logic [gai_pkg::FILL_W-1:0]           r_fill;
    logic [gai_pkg::RING_W-1:0]           rd_data;
    logic [gai_pkg::RING_W-1:0]           wr_data;
    logic signed [gai_pkg::CORR_W-1:0]    old_v [NA];
    logic signed [gai_pkg::CORR_W-1:0]    cur_v [NA];
    logic signed [gai_pkg::SUM_W-1:0]     r_sum [NA];
    logic signed [gai_pkg::SUM_W-1:0]     n_sum [NA];

    logic                                 r_s1_valid;
    logic                                 r_s1_en;
    logic [gai_pkg::DT_W-1:0]             r_s1_dt;
    logic signed [gai_pkg::SUM_W-1:0]     r_s1_sum [NA];

    logic signed [gai_pkg::SUM_W-1:0]     shifted [NA];
    logic signed [gai_pkg::RATE_W-1:0]    n_avg [NA];
    logic                                 r_s2_valid;
    logic                                 r_s2_en;
    logic signed [gai_pkg::RATE_W-1:0]    r_s2_avg [NA];
    logic signed [gai_pkg::PROD_W-1:0]    r_s2_prod [NA];

    logic                                 r_out_valid;
    logic signed [gai_pkg::RATE_W-1:0]    r_rate [NA];
    logic signed [gai_pkg::ANGLE_W-1:0]   r_angle [NA];

    // whole back end moves when the output register is free
    assign adv       = !r_out_valid || o_result.ready;
    assign o_q_pop   = adv && i_q_valid;
    assign take      = o_q_pop && i_q_item.en;
    assign ring_full = r_fill == gai_pkg::FILL_W'(gai_pkg::WINDOW);
    assign wr_data   = i_q_item.cur;

    // read address looks one slot ahead so the registered read is ready
    always_comb begin
        n_pos = r_pos;
        if (take) begin
            n_pos = (r_pos == gai_pkg::RING_AW'(gai_pkg::WINDOW - 1)) ? '0 : r_pos + 1'b1;
        end
    end

    gai_ram #(
        .WIDTH (gai_pkg::RING_W),
        .DEPTH (gai_pkg::WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (take),
        .i_waddr (r_pos),
        .i_wdata (wr_data),
        .i_raddr (n_pos),
        .o_rdata (rd_data)
    );

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            old_v[a] = $signed(rd_data[a*gai_pkg::CORR_W +: gai_pkg::CORR_W]);
            cur_v[a] = $signed(i_q_item.cur[a]);
            n_sum[a] = r_sum[a] + gai_pkg::SUM_W'(cur_v[a])
                     - (ring_full ? gai_pkg::SUM_W'(old_v[a]) : '0);
        end
    end

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            shifted[a] = r_s1_sum[a] >>> gai_pkg::SHIFT_K;
            if (shifted[a] > gai_pkg::SUM_RATE_HI) begin
                n_avg[a] = gai_pkg::RATE_W'(gai_pkg::RATE_MAX);
            end else if (shifted[a] < gai_pkg::SUM_RATE_LO) begin
                n_avg[a] = gai_pkg::RATE_W'(gai_pkg::RATE_MIN);
            end else begin
                n_avg[a] = shifted[a][gai_pkg::RATE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < NA; a++) begin
                r_sum[a]   <= '0;
                r_rate[a]  <= '0;
                r_angle[a] <= '0;
            end
        end else begin
            if (take) begin
                r_pos <= n_pos;
                if (!ring_full) begin
                    r_fill <= r_fill + 1'b1;
                end
                for (int a = 0; a < NA; a++) begin
                    r_sum[a] <= n_sum[a];
                end
            end
            if (adv) begin
                r_s1_valid  <= i_q_valid;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
                if (r_s2_valid && r_s2_en) begin
                    for (int a = 0; a < NA; a++) begin
                        r_rate[a]  <= r_s2_avg[a];
                        r_angle[a] <= r_angle[a] + gai_pkg::ANGLE_W'(r_s2_prod[a]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_en <= i_q_item.en;
            r_s1_dt <= i_q_item.dt;
            r_s2_en <= r_s1_en;
            for (int a = 0; a < NA; a++) begin
                r_s1_sum[a]  <= n_sum[a];
                r_s2_avg[a]  <= n_avg[a];
                r_s2_prod[a] <= n_avg[a] * $signed({1'b0, r_s1_dt});
            end
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.rate_x  = r_rate[0];
    assign o_result.rate_y  = r_rate[1];
    assign o_result.rate_z  = r_rate[2];
    assign o_result.angle_x = r_angle[0];
    assign o_result.angle_y = r_angle[1];
    assign o_result.angle_z = r_angle[2];

endmodule

`default_nettype wire
